// ===== hw/rtl/lrf_pkg.sv =====
// ----------------------------------------------------------------------------
// lrf_pkg: shared definitions for the line rasterizer frame store engine
// Screen geometry, field widths, command and state codes, and helpers for
// the on-screen test and row-major address calculation.
// ----------------------------------------------------------------------------
package lrf_pkg;

  localparam int SCREEN_COLS = 320;
  localparam int SCREEN_ROWS = 200;
  localparam int STORE_DEPTH = SCREEN_COLS * SCREEN_ROWS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int MODE_W  = 2;
  localparam int COORD_W = 11;
  localparam int COLOR_W = 8;
  localparam int CNT_W   = 12;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int ERR_W   = COORD_W + 4;
  localparam int MAX_POINTS = 1 << COORD_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_LINE = 2'd0,
    MODE_FILL = 2'd1,
    MODE_READ = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LINE,
    ST_FILL,
    ST_READ,
    ST_READ_WAIT,
    ST_RESULT
  } lrf_state_t;

  typedef struct packed {
    logic              on_screen;
    logic              at_end;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  count_total;
  } line_status_t;

  function automatic logic on_screen(input logic signed [COORD_W-1:0] x,
                                     input logic signed [COORD_W-1:0] y);
    logic x_ok;
    logic y_ok;
    x_ok = !x[COORD_W-1] && ({1'b0, x} < DIFF_W'(SCREEN_COLS));
    y_ok = !y[COORD_W-1] && ({1'b0, y} < DIFF_W'(SCREEN_ROWS));
    return x_ok && y_ok;
  endfunction

  // Row-major address; only meaningful for on-screen points.
  function automatic logic [ADDR_W-1:0] store_addr(input logic signed [COORD_W-1:0] x,
                                                   input logic signed [COORD_W-1:0] y);
    logic [31:0] prod;
    prod = 32'(y[COORD_W-2:0]) * 32'(SCREEN_COLS) + 32'(x[COORD_W-2:0]);
    return prod[ADDR_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/lrf_if.sv =====
// ----------------------------------------------------------------------------
// lrf_cmd_if / lrf_res_if: command and result channels
// Valid/ready channels; a transfer happens when valid and ready are high
// at a rising clock edge.
// ----------------------------------------------------------------------------
interface lrf_cmd_if;
  import lrf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic [COLOR_W-1:0]        color;

  modport source (output valid, mode, start_x, start_y, end_x, end_y, color,
                  input ready);
  modport sink (input valid, mode, start_x, start_y, end_x, end_y, color,
                output ready);
endinterface

interface lrf_res_if;
  import lrf_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_value;
  logic [CNT_W-1:0]   pixels_written;

  modport source (output valid, pixel_value, pixels_written, input ready);
  modport sink (input valid, pixel_value, pixels_written, output ready);
endinterface

// ===== hw/rtl/lrf_frame_mem.sv =====
// ----------------------------------------------------------------------------
// lrf_frame_mem: palette-index frame store
// Single-port synchronous memory, one access per cycle, read data
// registered and valid in the cycle after the read access.
// ----------------------------------------------------------------------------
module lrf_frame_mem (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          we,
  input  logic [lrf_pkg::ADDR_W-1:0]    addr,
  input  logic [lrf_pkg::COLOR_W-1:0]   wdata,
  output logic [lrf_pkg::COLOR_W-1:0]   rdata
);
  import lrf_pkg::*;

  logic [COLOR_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== hw/rtl/lrf_line_gen.sv =====
// ----------------------------------------------------------------------------
// lrf_line_gen: Bresenham point stepper
// Loads two endpoints, then advances one point per step and reports the
// current point's address, whether it is on screen, whether it is the end
// point, and the running count of on-screen points including this one.
// ----------------------------------------------------------------------------
module lrf_line_gen (
  input  logic                                clk,
  input  logic                                load,
  input  logic                                step,
  input  logic signed [lrf_pkg::COORD_W-1:0]  start_x,
  input  logic signed [lrf_pkg::COORD_W-1:0]  start_y,
  input  logic signed [lrf_pkg::COORD_W-1:0]  end_x,
  input  logic signed [lrf_pkg::COORD_W-1:0]  end_y,
  output lrf_pkg::line_status_t               status
);
  import lrf_pkg::*;

  logic signed [COORD_W-1:0] x;
  logic signed [COORD_W-1:0] y;
  logic signed [COORD_W-1:0] xe;
  logic signed [COORD_W-1:0] ye;
  logic signed [ERR_W-1:0]   dx;
  logic signed [ERR_W-1:0]   dy;
  logic signed [ERR_W-1:0]   err;
  logic                      sx_neg;
  logic                      sy_neg;
  logic [CNT_W-1:0]          count;

  logic signed [DIFF_W-1:0]  diff_x;
  logic signed [DIFF_W-1:0]  diff_y;
  logic signed [ERR_W-1:0]   abs_x;
  logic signed [ERR_W-1:0]   abs_y;
  logic signed [ERR_W-1:0]   e2;
  logic                      move_x;
  logic                      move_y;
  logic signed [ERR_W-1:0]   err_next;
  logic                      pt_on;

  always_comb begin
    diff_x = DIFF_W'(end_x) - DIFF_W'(start_x);
    diff_y = DIFF_W'(end_y) - DIFF_W'(start_y);
    abs_x  = diff_x[DIFF_W-1] ? -ERR_W'(diff_x) : ERR_W'(diff_x);
    abs_y  = diff_y[DIFF_W-1] ? -ERR_W'(diff_y) : ERR_W'(diff_y);

    e2       = err <<< 1;
    move_x   = (e2 >= dy);
    move_y   = (e2 <= dx);
    err_next = err + (move_x ? dy : '0) + (move_y ? dx : '0);

    pt_on = on_screen(x, y);
    status.on_screen   = pt_on;
    status.at_end      = (x == xe) && (y == ye);
    status.addr        = store_addr(x, y);
    status.count_total = count + CNT_W'(pt_on);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x      <= start_x;
      y      <= start_y;
      xe     <= end_x;
      ye     <= end_y;
      dx     <= abs_x;
      dy     <= -abs_y;
      err    <= abs_x - abs_y;
      sx_neg <= !(start_x < end_x);
      sy_neg <= !(start_y < end_y);
      count  <= '0;
    end else if (step) begin
      count <= status.count_total;
      err   <= err_next;
      if (move_x) begin
        x <= sx_neg ? x - COORD_W'(1) : x + COORD_W'(1);
      end
      if (move_y) begin
        y <= sy_neg ? y - COORD_W'(1) : y + COORD_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/line_rasterizer_framebuffer_top.sv =====
// ----------------------------------------------------------------------------
// line_rasterizer_framebuffer_top: 2D line drawing engine with frame store
// Owns a 320 x 200 store of 8-bit palette indices and executes one command
// at a time: draw a Bresenham line, fill the store, or read one pixel.
//
// Usage:
//   Commands arrive on the cmd channel and each produces exactly one result
//   transfer on the res channel. A line (mode 0) visits every point from
//   start to end, one point per cycle, storing the ones that are on screen,
//   and reports the number of stored points. A fill (mode 1) sweeps the
//   store at one entry per cycle. A read (mode 2) passes through the read,
//   read-wait and result states, limited by the single memory port and its
//   registered read. Mode 3 does nothing and returns zeros. After reset the
//   engine runs a clearing pass that writes zero to every entry; cmd.ready
//   stays low until it is done. The result sits in an output register, so a
//   new command is taken while the previous result still waits; if the
//   receiver stalls, a finished command holds in the result state until
//   the output register frees up.
// ----------------------------------------------------------------------------
module line_rasterizer_framebuffer_top (
  input  logic clk,
  input  logic rst,
  lrf_cmd_if.sink   cmd,
  lrf_res_if.source res
);
  import lrf_pkg::*;

  lrf_state_t state;
  lrf_state_t state_next;

  // Command registers.
  logic [COLOR_W-1:0]        draw_color;
  logic signed [COORD_W-1:0] rd_x;
  logic signed [COORD_W-1:0] rd_y;
  logic [ADDR_W-1:0]         sweep_addr;
  logic                      sweep_last;

  // Pending result and the output register.
  logic [COLOR_W-1:0] pend_value;
  logic [CNT_W-1:0]   pend_count;
  logic               out_valid;
  logic [COLOR_W-1:0] out_value;
  logic [CNT_W-1:0]   out_count;
  logic               out_free;

  // Memory port.
  logic               mem_en;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [COLOR_W-1:0] mem_wdata;
  logic [COLOR_W-1:0] mem_rdata;

  // Line stepper.
  logic         line_load;
  logic         line_step;
  line_status_t line_st;

  logic cmd_xfer;
  logic result_load;

  assign cmd_xfer   = cmd.valid && cmd.ready;
  assign out_free   = !out_valid || res.ready;
  assign sweep_last = (sweep_addr == ADDR_W'(STORE_DEPTH - 1));

  lrf_line_gen u_line_gen (
    .clk     (clk),
    .load    (line_load),
    .step    (line_step),
    .start_x (cmd.start_x),
    .start_y (cmd.start_y),
    .end_x   (cmd.end_x),
    .end_y   (cmd.end_y),
    .status  (line_st)
  );

  lrf_frame_mem u_frame_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.valid) begin
          case (cmd.mode)
            MODE_LINE: state_next = ST_LINE;
            MODE_FILL: state_next = ST_FILL;
            MODE_READ: state_next = ST_READ;
            default:   state_next = ST_RESULT;
          endcase
        end
      end
      ST_LINE: begin
        if (line_st.at_end) state_next = ST_RESULT;
      end
      ST_FILL: begin
        if (sweep_last) state_next = ST_RESULT;
      end
      ST_READ:      state_next = ST_READ_WAIT;
      ST_READ_WAIT: state_next = ST_RESULT;
      ST_RESULT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Output logic: handshake, memory port and stepper control.
  always_comb begin
    cmd.ready   = 1'b0;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = sweep_addr;
    mem_wdata   = draw_color;
    line_load   = 1'b0;
    line_step   = 1'b0;
    result_load = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        line_load = cmd.valid && (cmd.mode == MODE_LINE);
      end
      ST_CLEAR, ST_FILL: begin
        mem_en = 1'b1;
        mem_we = 1'b1;
      end
      ST_LINE: begin
        mem_en    = line_st.on_screen;
        mem_we    = line_st.on_screen;
        mem_addr  = line_st.addr;
        line_step = !line_st.at_end;
      end
      ST_READ: begin
        // An off-screen point has no entry; its result is forced to zero.
        mem_en   = on_screen(rd_x, rd_y);
        mem_addr = store_addr(rd_x, rd_y);
      end
      ST_RESULT: begin
        result_load = out_free;
      end
      default: begin
        mem_en = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The sweep counter and color also serve the clearing pass after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      draw_color <= '0;
    end else begin
      if (cmd_xfer) begin
        sweep_addr <= '0;
        draw_color <= cmd.color;
        rd_x       <= cmd.start_x;
        rd_y       <= cmd.start_y;
        pend_value <= '0;
        pend_count <= '0;
      end else if (state == ST_CLEAR || state == ST_FILL) begin
        sweep_addr <= sweep_addr + ADDR_W'(1);
      end
      if (state == ST_LINE && line_st.at_end) begin
        pend_count <= line_st.count_total;
      end
      if (state == ST_READ_WAIT) begin
        pend_value <= on_screen(rd_x, rd_y) ? mem_rdata : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_value <= pend_value;
      out_count <= pend_count;
    end
  end

  assign res.valid          = out_valid;
  assign res.pixel_value    = out_value;
  assign res.pixels_written = out_count;

  // An access never lands beyond the end of the store.
  a_addr_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_en |-> (32'(mem_addr) < 32'(STORE_DEPTH)))
    else $error("frame store access out of range");

  // A result never carries both a read value and a point count.
  a_one_field: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.pixels_written != '0) |-> (res.pixel_value == '0))
    else $error("result carries both a pixel value and a count");

  // A line's count never exceeds MAX_POINTS, the most points a line can visit.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LINE) |-> (32'(line_st.count_total) <= 32'(MAX_POINTS)))
    else $error("line point count out of range");

  // Reaching the end point finishes the line in the next cycle.
  a_line_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LINE && line_st.at_end) |=> (state == ST_RESULT))
    else $error("line did not finish at its end point");

  // A pending result moves into the output register when it is free.
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && out_free) |=> (res.valid && state == ST_IDLE))
    else $error("pending result was not presented");

endmodule
